// ===== rtl/sts_pkg.sv =====
// Shared constants and codes for the sorted table range search core.
`default_nettype none

package sts_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
   localparam int DATA_W      = 32;
   localparam int ACTION_W    = 2;
   localparam int INDEX_W     = 10;

   typedef enum logic [ACTION_W-1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_APPEND = 2'd1,
      ACT_QUERY  = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      COND_NEVER    = 3'd0,
      COND_ALWAYS   = 3'd1,
      COND_QUERY    = 3'd2,
      COND_EMPTY    = 3'd3,
      COND_LOOP     = 3'd4,
      COND_MATCH    = 3'd5,
      COND_LASTPASS = 3'd6,
      COND_OUTFREE  = 3'd7
   } cond_type;

   typedef enum logic [1:0] {
      RD_NONE  = 2'd0,
      RD_PROBE = 2'd1,
      RD_B     = 2'd2
   } rd_sel_type;

   typedef enum logic [1:0] {
      HIT_NONE = 2'd0,
      HIT_A    = 2'd1,
      HIT_B    = 2'd2
   } hit_sel_type;

endpackage

`default_nettype wire

// ===== rtl/sts_if.sv =====
// Request and response channel interfaces of the sorted table range search core.
`default_nettype none

interface sts_req_if;
   logic                               valid;
   logic                               ready;
   logic [sts_pkg::ACTION_W-1:0]       action;
   logic signed [sts_pkg::DATA_W-1:0]  item_value;

   modport source (output valid, action, item_value, input ready);
   modport sink   (input valid, action, item_value, output ready);
endinterface

interface sts_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          found;
   logic [sts_pkg::INDEX_W-1:0]   first_index;
   logic [sts_pkg::INDEX_W-1:0]   last_index;

   modport source (output valid, found, first_index, last_index, input ready);
   modport sink   (input valid, found, first_index, last_index, output ready);
endinterface

`default_nettype wire

// ===== rtl/sts_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none

module sts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/sorted_table_range_search_core.sv =====
// Top level: sorted table with first/last occurrence search run by a microcoded sequencer.
//
//   channel   dir   handshake        payload
//   req_bus   in    valid / ready    action, item_value
//   rsp_bus   out   valid / ready    found, first_index, last_index
//
// Clear and append are taken in the idle step. A query holds the sequencer until its
// response is registered; an empty table goes straight to the output step. Each probe
// of the table costs two steps (issue the read, compare the registered read data).
// Reset clears the entry count, the sequencer, the pass and hit flags and the response valid flag.
// A finished response waits in its output register; the next request is
// taken meanwhile, and only a second result stalls the sequencer.
`default_nettype none

module sorted_table_range_search_core (
   input  wire logic clock,
   input  wire logic reset,
   sts_req_if.sink   req_bus,
   sts_rsp_if.source rsp_bus
);

   localparam int AW = sts_pkg::ADDR_W;
   localparam int CW = sts_pkg::COUNT_W;
   localparam int DW = sts_pkg::DATA_W;
   localparam int IW = sts_pkg::INDEX_W;

   typedef enum logic [2:0] {
      ST_IDLE = 3'd0,
      ST_INIT = 3'd1,
      ST_TEST = 3'd2,
      ST_CMP  = 3'd3,
      ST_CHKA = 3'd4,
      ST_CHKB = 3'd5,
      ST_NEXT = 3'd6,
      ST_OUT  = 3'd7
   } step_type;

   typedef struct packed {
      step_type             next_step;
      step_type             jump_step;
      sts_pkg::cond_type    cond;
      sts_pkg::rd_sel_type  rd_sel;
      sts_pkg::hit_sel_type hit_sel;
      logic                 ready;
      logic                 init;
      logic                 narrow;
      logic                 set_pass;
      logic                 emit;
   } ucode_type;

   // Control store: jump when the condition holds, else fall to next_step.
   function automatic ucode_type ucode_rom(step_type step);
      ucode_type w;
      w = '{next_step: ST_IDLE, jump_step: ST_IDLE, cond: sts_pkg::COND_NEVER,
            rd_sel: sts_pkg::RD_NONE, hit_sel: sts_pkg::HIT_NONE, ready: 1'b0,
            init: 1'b0, narrow: 1'b0, set_pass: 1'b0, emit: 1'b0};
      unique case (step)
         ST_IDLE: begin
            w.next_step = ST_IDLE;  w.jump_step = ST_INIT;
            w.cond = sts_pkg::COND_QUERY;
            w.ready = 1'b1;
         end
         ST_INIT: begin
            w.next_step = ST_TEST;  w.jump_step = ST_OUT;
            w.cond = sts_pkg::COND_EMPTY;
            w.init = 1'b1;
         end
         ST_TEST: begin
            w.next_step = ST_CHKA;  w.jump_step = ST_CMP;
            w.cond = sts_pkg::COND_LOOP;
            w.rd_sel = sts_pkg::RD_PROBE;
         end
         ST_CMP: begin
            w.next_step = ST_TEST;  w.jump_step = ST_TEST;
            w.cond = sts_pkg::COND_ALWAYS;
            w.narrow = 1'b1;
         end
         ST_CHKA: begin
            w.next_step = ST_CHKB;  w.jump_step = ST_NEXT;
            w.cond = sts_pkg::COND_MATCH;
            w.rd_sel = sts_pkg::RD_B;  w.hit_sel = sts_pkg::HIT_A;
         end
         ST_CHKB: begin
            w.next_step = ST_NEXT;  w.jump_step = ST_NEXT;
            w.cond = sts_pkg::COND_NEVER;
            w.hit_sel = sts_pkg::HIT_B;
         end
         ST_NEXT: begin
            w.next_step = ST_INIT;  w.jump_step = ST_OUT;
            w.cond = sts_pkg::COND_LASTPASS;
            w.set_pass = 1'b1;
         end
         ST_OUT: begin
            w.next_step = ST_OUT;   w.jump_step = ST_IDLE;
            w.cond = sts_pkg::COND_OUTFREE;
            w.emit = 1'b1;
         end
         default: begin
            w.next_step = ST_IDLE;
         end
      endcase
      return w;
   endfunction

   step_type            step_ff, step_in;
   ucode_type           uw;
   sts_pkg::action_type req_action;

   logic [CW-1:0]        count_ff, count_in;
   logic [AW-1:0]        lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [AW-1:0]        first_ff, first_in, last_ff, last_in;
   logic signed [DW-1:0] key_ff, key_in;
   logic                 pass_ff, pass_in;
   logic                 hit_first_ff, hit_first_in, hit_last_ff, hit_last_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 found_ff, found_in;
   logic [IW-1:0]        first_out_ff, first_out_in, last_out_ff, last_out_in;

   logic                 req_fire, loop_go, match, cond_true, out_free;
   logic [AW-1:0]        mid, probe_a, probe_b, hit_pos;
   logic                 wr_en, rd_en;
   logic [AW-1:0]        rd_addr;
   logic signed [DW-1:0] rd_data;

   sts_ram #(
      .WIDTH (DW),
      .DEPTH (sts_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_bus.item_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign uw              = ucode_rom(step_ff);
   assign req_action      = sts_pkg::action_type'(req_bus.action);
   assign req_bus.ready   = uw.ready;
   assign req_fire        = req_bus.valid & req_bus.ready;
   assign out_free        = !rsp_valid_ff || rsp_bus.ready;

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.found       = found_ff;
   assign rsp_bus.first_index = first_out_ff;
   assign rsp_bus.last_index  = last_out_ff;

   // first pass leans left, second pass (pass_ff set) leans right
   assign loop_go = ({1'b0, lo_ff} + {{AW{1'b0}}, 1'b1}) < {1'b0, hi_ff};
   assign mid     = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign probe_a = pass_ff ? hi_ff : lo_ff;
   assign probe_b = pass_ff ? lo_ff : hi_ff;
   assign hit_pos = (uw.hit_sel == sts_pkg::HIT_A) ? probe_a : probe_b;
   assign match   = (rd_data == key_ff);

   assign wr_en = req_fire && (req_action == sts_pkg::ACT_APPEND)
                  && (count_ff != CW'(sts_pkg::TABLE_DEPTH));

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = probe_b;
      unique case (uw.rd_sel)
         sts_pkg::RD_PROBE: begin
            rd_en   = 1'b1;
            rd_addr = loop_go ? mid : probe_a;
         end
         sts_pkg::RD_B: begin
            rd_en   = 1'b1;
            rd_addr = probe_b;
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      unique case (uw.cond)
         sts_pkg::COND_NEVER:    cond_true = 1'b0;
         sts_pkg::COND_ALWAYS:   cond_true = 1'b1;
         sts_pkg::COND_QUERY:    cond_true = req_fire && (req_action == sts_pkg::ACT_QUERY);
         sts_pkg::COND_EMPTY:    cond_true = (count_ff == '0);
         sts_pkg::COND_LOOP:     cond_true = loop_go;
         sts_pkg::COND_MATCH:    cond_true = match;
         sts_pkg::COND_LASTPASS: cond_true = pass_ff;
         sts_pkg::COND_OUTFREE:  cond_true = out_free;
         default:                cond_true = 1'b0;
      endcase
   end

   always_comb begin
      step_in      = cond_true ? uw.jump_step : uw.next_step;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      key_in       = key_ff;
      pass_in      = pass_ff;
      hit_first_in = hit_first_ff;
      hit_last_in  = hit_last_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff;
      found_in     = found_ff;
      first_out_in = first_out_ff;
      last_out_in  = last_out_ff;

      if (req_fire) begin
         unique case (req_action)
            sts_pkg::ACT_CLEAR:  count_in = '0;
            sts_pkg::ACT_APPEND: if (wr_en) count_in = count_ff + CW'(1);
            sts_pkg::ACT_QUERY: begin
               key_in       = req_bus.item_value;
               pass_in      = 1'b0;
               hit_first_in = 1'b0;
               hit_last_in  = 1'b0;
            end
            default: ;
         endcase
      end

      if (uw.init) begin
         lo_in = '0;
         hi_in = AW'(count_ff - CW'(1));
      end

      if (uw.rd_sel == sts_pkg::RD_PROBE) begin
         mid_in = mid;
      end

      if (uw.narrow) begin
         if (rd_data == key_ff) begin
            if (pass_ff) lo_in = mid_ff;
            else         hi_in = mid_ff;
         end else if (rd_data > key_ff) begin
            hi_in = mid_ff;
         end else begin
            lo_in = mid_ff;
         end
      end

      if ((uw.hit_sel != sts_pkg::HIT_NONE) && match) begin
         if (pass_ff) begin
            hit_last_in = 1'b1;
            last_in     = hit_pos;
         end else begin
            hit_first_in = 1'b1;
            first_in     = hit_pos;
         end
      end

      if (uw.set_pass) begin
         pass_in = 1'b1;
      end

      if (uw.emit && out_free) begin
         rsp_valid_in = 1'b1;
         found_in     = hit_first_ff | hit_last_ff;
         first_out_in = hit_first_ff ? IW'(first_ff) : '0;
         last_out_in  = hit_last_ff ? IW'(last_ff) : '0;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_IDLE;
         count_ff     <= '0;
         pass_ff      <= 1'b0;
         hit_first_ff <= 1'b0;
         hit_last_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         count_ff     <= count_in;
         pass_ff      <= pass_in;
         hit_first_ff <= hit_first_in;
         hit_last_ff  <= hit_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      key_ff       <= key_in;
      first_ff     <= first_in;
      last_ff      <= last_in;
      found_ff     <= found_in;
      first_out_ff <= first_out_in;
      last_out_ff  <= last_out_in;
   end

   // probe point lies strictly inside the current bounds
   assert property (@(posedge clock) disable iff (reset)
      step_ff == ST_CMP |-> (mid_ff > lo_ff) && (mid_ff < hi_ff))
      else $error("probe outside search bounds");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(sts_pkg::TABLE_DEPTH))
      else $error("entry count beyond table depth");

   assert property (@(posedge clock) disable iff (reset)
      (step_ff == ST_OUT) && hit_first_ff |-> CW'(first_ff) < count_ff)
      else $error("first hit index beyond stored entries");

   assert property (@(posedge clock) disable iff (reset)
      (step_ff == ST_OUT) && hit_last_ff |-> CW'(last_ff) < count_ff)
      else $error("last hit index beyond stored entries");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(step_ff) == ST_OUT)
      else $error("response raised outside the output step");

endmodule

`default_nettype wire
